>>> design/pcta_pkg.sv
package pcta_pkg;

  localparam int NUM_CPUS = 16;
  localparam int CPU_W = 4;
  localparam int TS_W = 64;
  localparam int TID_W = 31;
  localparam int PER_W = 40;
  localparam int AMT_W = 40;
  localparam int CAT_W = 3;
  localparam int ADDR_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(64'd1000000000);

  localparam logic OP_SWITCH = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CAT_W-1:0] CAT_NONE = 3'd0;
  localparam logic [CAT_W-1:0] CAT_IDLE = 3'd1;
  localparam logic [CAT_W-1:0] CAT_UNKNOWN = 3'd2;
  localparam logic [CAT_W-1:0] CAT_SERVER = 3'd3;
  localparam logic [CAT_W-1:0] CAT_OTHER = 3'd4;

  // Per-CPU entry held in the state memory.
  typedef struct packed {
    logic [TS_W-1:0] last_time;
    logic [TID_W-1:0] last_tid;
    logic [TS_W-1:0] idle_acc;
    logic [TS_W-1:0] unknown_acc;
    logic [TS_W-1:0] server_acc;
    logic [TS_W-1:0] other_acc;
    logic [TS_W-1:0] eff_start;
  } cpu_entry_t;

  localparam int ENTRY_W = $bits(cpu_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIVIDE,
    ST_CLIP,
    ST_CHARGE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

>>> design/pcta_ram.sv
module pcta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/pcta_div.sv
module pcta_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcta_pkg::TS_W-1:0]  dividend,
  input  logic [pcta_pkg::PER_W-1:0] divisor,
  output pcta_pkg::div_ctl_t         ctl,
  output logic [pcta_pkg::PER_W-1:0] remainder
);
  import pcta_pkg::*;

  // Restoring divider, one quotient bit a cycle.
  logic [TS_W-1:0] quo;
  logic [PER_W:0] rem;
  logic [6:0] count;
  logic active;
  logic [PER_W:0] trial;
  logic [PER_W:0] shifted;

  always_comb begin
    shifted = {rem[PER_W-1:0], quo[TS_W-1]};
    trial = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count <= '0;
    end else if (start) begin
      active <= 1'b1;
      count <= 7'(TS_W);
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      if (!trial[PER_W]) begin
        rem <= trial;
        quo <= {quo[TS_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[TS_W-2:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        active <= 1'b0;
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy = active;
  assign remainder = rem[PER_W-1:0];

endmodule

>>> design/per_cpu_time_accounting.sv
// Channel  | Direction | Handshake              | Payload
// config   | in        | sample_period_ns_we    | sample_period_ns_wdata
// item     | in        | start / busy           | operation .. thread_is_server
// result   | out       | done strobe            | result_cpu .. effective_length_ns
//
// An item's result shows after READ, CHECK, CHARGE and WRITE; the first
// switch of a CPU, a flush of a fresh CPU or an out-of-range CPU skips CHARGE,
// and a gap that needs clipping adds DIVIDE, for the 64-step divider, and CLIP.
// busy stays high until the cycle the result shows, so the next item can be
// accepted at the edge that takes the result.
// Reset sweeps every entry of the per-CPU state memory to zero; busy is high
// during the sweep, and configuration writes are taken throughout.
// Each result shows for one cycle on done; the receiver cannot stall.
module per_cpu_time_accounting (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_period_ns_we,
  input  logic [pcta_pkg::PER_W-1:0]          sample_period_ns_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [pcta_pkg::CPU_W-1:0]          cpu_index,
  input  logic [pcta_pkg::TS_W-1:0]           timestamp_ns,
  input  logic [pcta_pkg::TID_W-1:0]          incoming_tid,
  input  logic                                thread_known,
  input  logic                                thread_is_server,
  output logic                                done,
  output logic [pcta_pkg::CPU_W-1:0]          result_cpu,
  output logic [pcta_pkg::AMT_W-1:0]          attributed_ns,
  output logic [pcta_pkg::CAT_W-1:0]          category,
  output logic                                snapshot_valid,
  output logic [pcta_pkg::TS_W-1:0]           idle_total_ns,
  output logic [pcta_pkg::TS_W-1:0]           other_total_ns,
  output logic [pcta_pkg::TS_W-1:0]           unknown_total_ns,
  output logic [pcta_pkg::TS_W-1:0]           server_total_ns,
  output logic [pcta_pkg::TS_W-1:0]           effective_length_ns
);
  import pcta_pkg::*;

  // Configuration register.
  logic [PER_W-1:0] period;
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (sample_period_ns_we) begin
      period <= sample_period_ns_wdata;
    end
  end

  // Period zero counts as one.
  logic [PER_W-1:0] per_eff;
  assign per_eff = (period == '0) ? PER_W'(1) : period;

  // Latched item.
  logic op_r, known_r, server_r, in_range;
  logic [CPU_W-1:0] cpu_r;
  logic [TS_W-1:0] ts_r;
  logic [TID_W-1:0] tid_r;

  // Working copy of the entry and per-item scratch.
  cpu_entry_t ent;
  cpu_entry_t rd_data;
  logic [TS_W-1:0] u_ts;      // charge time
  logic [TID_W-1:0] u_tid;    // thread recorded by the charge
  logic [TS_W-1:0] u_hold;
  logic [TID_W-1:0] tid_hold;
  logic [TS_W-1:0] delta;
  logic [TS_W-1:0] prod;
  logic first_evt;
  logic first_now;

  // Reset clearing sweep.
  logic clearing;
  logic [ADDR_W:0] clr_cnt;

  state_t state, state_next;

  // Divider for the period start.
  div_ctl_t dctl;
  logic [PER_W-1:0] remainder;
  logic div_go;

  pcta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (u_ts),
    .divisor   (per_eff),
    .ctl       (dctl),
    .remainder (remainder)
  );

  // State memory.
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  cpu_entry_t mem_wdata;
  cpu_entry_t ent_wr;

  pcta_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << ADDR_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign mem_raddr = cpu_r[ADDR_W-1:0];
  assign mem_we = clearing || (state == ST_WRITE && in_range);
  assign mem_waddr = clearing ? clr_cnt[ADDR_W-1:0] : cpu_r[ADDR_W-1:0];
  assign mem_wdata = clearing ? '0 : ent_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt[ADDR_W-1:0] == ADDR_W'(NUM_CPUS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing || (state != ST_IDLE);
  assign div_go = (state == ST_CHECK) && state_next == ST_DIVIDE;

  // The entry read in CHECK is used through ent after that; in CHECK itself
  // work from rd_data via a muxed view.
  cpu_entry_t cur;
  assign cur = (state == ST_CHECK) ? rd_data : ent;
  assign first_now = (rd_data.last_time == '0);

  // Signed delta check: positive and above the period.
  logic [TS_W-1:0] d_raw;
  logic gap_long;
  assign d_raw = u_ts - cur.last_time;
  assign gap_long = !d_raw[TS_W-1] && (d_raw > {{(TS_W-PER_W){1'b0}}, per_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !clearing) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!in_range || first_now) begin
          state_next = ST_WRITE;
        end else if (gap_long) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_CHARGE;
        end
      end
      ST_DIVIDE: begin
        if (!dctl.busy && !dctl.start) begin
          state_next = ST_CLIP;
        end
      end
      ST_CLIP: state_next = ST_CHARGE;
      ST_CHARGE: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && !clearing) begin
            op_r <= operation;
            cpu_r <= cpu_index;
            ts_r <= timestamp_ns;
            tid_r <= incoming_tid;
            known_r <= thread_known;
            server_r <= thread_is_server;
            in_range <= (32'(cpu_index) < NUM_CPUS);
            result_cpu <= cpu_index;
            attributed_ns <= '0;
            category <= CAT_NONE;
            snapshot_valid <= 1'b0;
            idle_total_ns <= '0;
            other_total_ns <= '0;
            unknown_total_ns <= '0;
            server_total_ns <= '0;
            effective_length_ns <= '0;
          end
        end
        ST_READ: begin
          // Memory data lands at the end of this cycle.
        end
        ST_CHECK: begin
          // Capture the entry from memory; the charge time is set up in this state too.
          ent <= rd_data;
        end
        ST_DIVIDE: begin
        end
        ST_CLIP: begin
          if (ent.last_time < prod) begin
            ent.last_time <= prod;
          end
        end
        ST_CHARGE: begin
          if (!delta[TS_W-1] && delta != '0) begin
            if (!known_r) begin
              if (ent.last_tid == '0) begin
                ent.idle_acc <= ent.idle_acc + delta;
                category <= CAT_IDLE;
              end else begin
                ent.unknown_acc <= ent.unknown_acc + delta;
                category <= CAT_UNKNOWN;
              end
            end else if (server_r) begin
              ent.server_acc <= ent.server_acc + delta;
              category <= CAT_SERVER;
            end else begin
              ent.other_acc <= ent.other_acc + delta;
              category <= CAT_OTHER;
            end
            ent.last_time <= u_hold;
            ent.last_tid <= tid_hold;
            attributed_ns <= delta[AMT_W-1:0];
          end
        end
        ST_WRITE: begin
          done <= 1'b1;
          if (in_range && op_r == OP_FLUSH && !first_evt) begin
            snapshot_valid <= 1'b1;
            idle_total_ns <= ent.idle_acc;
            other_total_ns <= ent.other_acc;
            unknown_total_ns <= ent.unknown_acc;
            server_total_ns <= ent.server_acc;
            effective_length_ns <= u_hold - ent.eff_start;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Charge time and thread: a switch charges to ts; a flush to ts-1 clamped.
  always_comb begin
    u_tid = (op_r == OP_FLUSH) ? cur.last_tid : tid_r;
    if (op_r == OP_FLUSH) begin
      u_ts = ((ts_r - 64'd1) < cur.last_time) ? cur.last_time : ts_r - 64'd1;
    end else begin
      u_ts = ts_r;
    end
  end

  // u_ts depends on last_time, which CLIP may raise; hold it stable.
  // The period start is the charge time less its remainder by the period.
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      u_hold <= u_ts;
      tid_hold <= u_tid;
      first_evt <= first_now;
    end
    if (state == ST_DIVIDE) begin
      prod <= u_hold - {{(TS_W-PER_W){1'b0}}, remainder};
    end
  end

  assign delta = u_hold - ent.last_time;

  // Final entry image is set up in WRITE via a small comb override.
  always_comb begin
    ent_wr = ent;
    if (first_evt) begin
      if (op_r == OP_SWITCH) begin
        ent_wr.last_time = ts_r;
        ent_wr.last_tid = tid_r;
        ent_wr.eff_start = ts_r;
      end
    end else if (op_r == OP_FLUSH) begin
      ent_wr.last_time = ts_r;
      ent_wr.idle_acc = '0;
      ent_wr.other_acc = '0;
      ent_wr.unknown_acc = '0;
      ent_wr.server_acc = '0;
      ent_wr.eff_start = u_hold;
    end
  end

endmodule

>>> design/pcta_checker.sv
module pcta_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [pcta_pkg::CAT_W-1:0] category,
  input logic snapshot_valid,
  input logic [63:0] idle_total_ns
);
  import pcta_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without item");
  a_snap_cat: assert property (@(posedge clk) disable iff (rst)
    done && !snapshot_valid |-> idle_total_ns == '0) else $error("stray snapshot");
  a_cat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> category <= CAT_OTHER) else $error("category out of range");

endmodule

bind per_cpu_time_accounting pcta_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .category(category), .snapshot_valid(snapshot_valid),
  .idle_total_ns(idle_total_ns)
);
